@@ rtl/segment_square_crossing_assert.svh @@
// Assertion macros for the segment square crossing block
`ifndef SEGMENT_SQUARE_CROSSING_ASSERT_SVH
`define SEGMENT_SQUARE_CROSSING_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define SSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked on every clock edge outside reset
`define SSC_ASSERT_ALW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

@@ rtl/ssc_pkg.sv @@
// Shared types, constants and helper functions of the segment square crossing block
`timescale 1ns / 1ps

package ssc_pkg;

  localparam int CoordFracBits = 8;
  localparam int FracBits      = 16;
  localparam int CoordW        = 24;
  localparam int CenterW       = 16;
  localparam int HalfW         = 15;
  localparam int DeltaW        = CoordW + 1;
  localparam int EdgeW         = CenterW + CoordFracBits + 1;
  localparam int NumW          = 26;
  localparam int QuotW         = FracBits + 2;
  localparam int RemW          = NumW + 2;
  localparam int ProdW         = DeltaW + QuotW;
  localparam int PartW         = ProdW - FracBits;
  localparam int InterW        = PartW + 2;
  localparam int Lanes         = 4;
  localparam int DivStages     = QuotW;

  localparam logic [QuotW-1:0] FracNone = QuotW'(2) << FracBits;
  localparam logic [QuotW-1:0] FracOne  = QuotW'(1) << FracBits;

  // Configuration register indexes
  localparam logic [1:0] RegCenterX   = 2'd0;
  localparam logic [1:0] RegCenterY   = 2'd1;
  localparam logic [1:0] RegHalfWidth = 2'd2;

  // Edge lanes, in test order
  localparam logic [1:0] LaneLeft   = 2'd0;
  localparam logic [1:0] LaneRight  = 2'd1;
  localparam logic [1:0] LaneTop    = 2'd2;
  localparam logic [1:0] LaneBottom = 2'd3;

  typedef struct packed {
    logic signed [EdgeW-1:0] left;
    logic signed [EdgeW-1:0] right;
    logic signed [EdgeW-1:0] top;
    logic signed [EdgeW-1:0] bottom;
  } edges_t;

  // One classified segment, as it travels from front to back
  typedef struct packed {
    logic signed [CoordW-1:0]   sx;
    logic signed [CoordW-1:0]   sy;
    logic signed [CoordW-1:0]   sz;
    logic signed [DeltaW-1:0]   dx;
    logic signed [DeltaW-1:0]   dy;
    logic signed [DeltaW-1:0]   dz;
    logic [DeltaW-1:0]          dmx;
    logic [DeltaW-1:0]          dmy;
    logic [DeltaW-1:0]          dmz;
    logic [Lanes-1:0][NumW-1:0] num_mag;
    logic [Lanes-1:0]           ok;
  } item_t;

  function automatic logic [DeltaW-1:0] mag_delta(input logic signed [DeltaW-1:0] v);
    mag_delta = v[DeltaW-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  function automatic logic [NumW-1:0] mag_num(input logic signed [NumW-1:0] v);
    mag_num = v[NumW-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  // start + or - the scaled part, by the sign of the extent
  function automatic logic signed [InterW-1:0] interp(
    input logic signed [CoordW-1:0] s,
    input logic signed [DeltaW-1:0] d,
    input logic [PartW-1:0]         p
  );
    logic signed [InterW-1:0] se;
    logic signed [InterW-1:0] pe;
    se = InterW'(s);
    pe = $signed({2'b00, p});
    interp = d[DeltaW-1] ? se - pe : se + pe;
  endfunction

endpackage

@@ rtl/segment_square_crossing.sv @@
// Top level of the segment square crossing block
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_ready  | start_x/y/z, end_x/y/z (24b signed, Q.8)
//   out     | out_valid/out_ready| crossed, fraction (18b, Q.16), impact_x/y/z
//   cfg     | cfg_we             | cfg_idx, cfg_wdata (center x, center y, half)
//
// One segment per cycle sustained while out_ready does not stall the output; a segment
// passes the front register, the queue, the divider stages (one per quotient bit) and then
// the product, span, select, depth product and output registers.
// Reset (rst_n low, synchronous) empties every stage and the queue and loads
// center 0,0 and half width 0.5.
// An output stall freezes the back end; the queue and front register keep
// taking segments until four plus one are waiting.
`timescale 1ns / 1ps
`include "segment_square_crossing_assert.svh"

module segment_square_crossing (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ssc_pkg::CoordW-1:0]   in_start_x,
  input  logic signed [ssc_pkg::CoordW-1:0]   in_start_y,
  input  logic signed [ssc_pkg::CoordW-1:0]   in_start_z,
  input  logic signed [ssc_pkg::CoordW-1:0]   in_end_x,
  input  logic signed [ssc_pkg::CoordW-1:0]   in_end_y,
  input  logic signed [ssc_pkg::CoordW-1:0]   in_end_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_crossed,
  output logic [ssc_pkg::QuotW-1:0]           out_fraction,
  output logic signed [ssc_pkg::CoordW-1:0]   out_impact_x,
  output logic signed [ssc_pkg::CoordW-1:0]   out_impact_y,
  output logic signed [ssc_pkg::CoordW-1:0]   out_impact_z,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_idx,
  input  logic [ssc_pkg::CenterW-1:0]         cfg_wdata
);

  logic signed [ssc_pkg::CenterW-1:0] cx_r, cy_r;
  logic [ssc_pkg::HalfW-1:0]          hw_r;
  logic signed [ssc_pkg::EdgeW-1:0]   base_x, base_y, hw_ext;
  ssc_pkg::edges_t                    edges;
  logic                               fq_valid, fq_ready;
  ssc_pkg::item_t                     fq_item;
  logic                               qb_valid, qb_ready;
  ssc_pkg::item_t                     qb_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      hw_r <= ssc_pkg::HalfW'(128);
    end else if (cfg_we) begin
      case (cfg_idx)
        ssc_pkg::RegCenterX:   cx_r <= cfg_wdata;
        ssc_pkg::RegCenterY:   cy_r <= cfg_wdata;
        ssc_pkg::RegHalfWidth: hw_r <= cfg_wdata[ssc_pkg::HalfW-1:0];
        default: ;
      endcase
    end
  end

  // Cell edges from the grid center and half width
  assign base_x = $signed({cx_r[ssc_pkg::CenterW-1], cx_r, {ssc_pkg::CoordFracBits{1'b0}}});
  assign base_y = $signed({cy_r[ssc_pkg::CenterW-1], cy_r, {ssc_pkg::CoordFracBits{1'b0}}});
  assign hw_ext = $signed({{(ssc_pkg::EdgeW-ssc_pkg::HalfW){1'b0}}, hw_r});

  assign edges.left   = base_x - hw_ext;
  assign edges.right  = base_x + hw_ext;
  assign edges.top    = base_y - hw_ext;
  assign edges.bottom = base_y + hw_ext;

  ssc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_start_z (in_start_z),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .in_end_z   (in_end_z),
    .edges      (edges),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item)
  );

  ssc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  ssc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (qb_valid),
    .pop_ready    (qb_ready),
    .pop_item     (qb_item),
    .edges        (edges),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_crossed  (out_crossed),
    .out_fraction (out_fraction),
    .out_impact_x (out_impact_x),
    .out_impact_y (out_impact_y),
    .out_impact_z (out_impact_z)
  );

  // A miss reports no impact point
  `SSC_ASSERT_IMP(a_miss_zero, out_valid && !out_crossed,
    out_impact_x == '0 && out_impact_y == '0 && out_impact_z == '0,
    "impact point not zero on a miss")

  // A crossing never lies beyond the segment end
  `SSC_ASSERT_IMP(a_cross_frac, out_valid && out_crossed,
    out_fraction <= ssc_pkg::FracOne, "crossing with fraction above one")

  // Fraction never exceeds the no-crossing mark
  `SSC_ASSERT_ALW(a_frac_range, !out_valid || out_fraction <= ssc_pkg::FracNone,
    "fraction above two")

endmodule

@@ rtl/ssc_front.sv @@
// Front end: input register and per-edge classification of each segment
`timescale 1ns / 1ps

module ssc_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ssc_pkg::CoordW-1:0]    in_start_x,
  input  logic signed [ssc_pkg::CoordW-1:0]    in_start_y,
  input  logic signed [ssc_pkg::CoordW-1:0]    in_start_z,
  input  logic signed [ssc_pkg::CoordW-1:0]    in_end_x,
  input  logic signed [ssc_pkg::CoordW-1:0]    in_end_y,
  input  logic signed [ssc_pkg::CoordW-1:0]    in_end_z,
  input  ssc_pkg::edges_t                      edges,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output ssc_pkg::item_t                       push_item
);

  logic f_vld_r, f_vld_nxt;
  logic signed [ssc_pkg::CoordW-1:0] sx_r, sy_r, sz_r, ex_r, ey_r, ez_r;
  logic signed [ssc_pkg::DeltaW-1:0] dx, dy, dz;
  logic signed [ssc_pkg::EdgeW-1:0]  e_lane [ssc_pkg::Lanes];
  logic signed [ssc_pkg::CoordW-1:0] s_lane [ssc_pkg::Lanes];
  logic signed [ssc_pkg::DeltaW-1:0] d_lane [ssc_pkg::Lanes];
  logic signed [ssc_pkg::NumW-1:0]   num    [ssc_pkg::Lanes];

  assign in_ready   = !f_vld_r || push_ready;
  assign push_valid = f_vld_r;

  // Hold register: refilled on a transfer, emptied when the queue takes it
  always_comb begin
    f_vld_nxt = f_vld_r;
    if (in_valid && in_ready) begin
      f_vld_nxt = 1'b1;
    end else if (push_ready) begin
      f_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sx_r <= in_start_x;
      sy_r <= in_start_y;
      sz_r <= in_start_z;
      ex_r <= in_end_x;
      ey_r <= in_end_y;
      ez_r <= in_end_z;
    end
  end

  // Extents
  assign dx = $signed({ex_r[ssc_pkg::CoordW-1], ex_r}) - $signed({sx_r[ssc_pkg::CoordW-1], sx_r});
  assign dy = $signed({ey_r[ssc_pkg::CoordW-1], ey_r}) - $signed({sy_r[ssc_pkg::CoordW-1], sy_r});
  assign dz = $signed({ez_r[ssc_pkg::CoordW-1], ez_r}) - $signed({sz_r[ssc_pkg::CoordW-1], sz_r});

  // Lane operands: left/right on x, top/bottom on y
  always_comb begin
    e_lane[ssc_pkg::LaneLeft]   = edges.left;
    e_lane[ssc_pkg::LaneRight]  = edges.right;
    e_lane[ssc_pkg::LaneTop]    = edges.top;
    e_lane[ssc_pkg::LaneBottom] = edges.bottom;
    s_lane[ssc_pkg::LaneLeft]   = sx_r;
    s_lane[ssc_pkg::LaneRight]  = sx_r;
    s_lane[ssc_pkg::LaneTop]    = sy_r;
    s_lane[ssc_pkg::LaneBottom] = sy_r;
    d_lane[ssc_pkg::LaneLeft]   = dx;
    d_lane[ssc_pkg::LaneRight]  = dx;
    d_lane[ssc_pkg::LaneTop]    = dy;
    d_lane[ssc_pkg::LaneBottom] = dy;
  end

  // Distance to each edge; skip on zero extent or when moving away
  always_comb begin
    push_item.sx  = sx_r;
    push_item.sy  = sy_r;
    push_item.sz  = sz_r;
    push_item.dx  = dx;
    push_item.dy  = dy;
    push_item.dz  = dz;
    push_item.dmx = ssc_pkg::mag_delta(dx);
    push_item.dmy = ssc_pkg::mag_delta(dy);
    push_item.dmz = ssc_pkg::mag_delta(dz);
    for (int i = 0; i < ssc_pkg::Lanes; i++) begin
      num[i] = ssc_pkg::NumW'(e_lane[i]) - ssc_pkg::NumW'(s_lane[i]);
      push_item.num_mag[i] = ssc_pkg::mag_num(num[i]);
      push_item.ok[i] = (d_lane[i] != '0) &&
                        !((num[i] != '0) && (num[i][ssc_pkg::NumW-1] != d_lane[i][ssc_pkg::DeltaW-1]));
    end
  end

endmodule

@@ rtl/ssc_queue.sv @@
// Short queue between the front end and the back end
`timescale 1ns / 1ps

module ssc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  ssc_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ssc_pkg::item_t pop_item
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  ssc_pkg::item_t  entry_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]   cnt_r, cnt_nxt;
  logic            push, pop;

  assign push_ready = (cnt_r != (PtrW+1)'(Depth));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/ssc_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, range 0 to just under 4.0
`timescale 1ns / 1ps

module ssc_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [ssc_pkg::NumW-1:0]         num,
  input  logic [ssc_pkg::DeltaW-1:0]       den,
  input  logic                             ok_in,
  output logic [ssc_pkg::QuotW-1:0]        quot,
  output logic                             ok_out
);

  localparam int N  = ssc_pkg::DivStages;
  localparam int RW = ssc_pkg::RemW;
  localparam int QW = ssc_pkg::QuotW;
  localparam int DW = ssc_pkg::DeltaW;

  logic [RW-1:0] rem_r [N-1];
  logic [DW-1:0] den_r [N-1];
  logic [QW-1:0] q_r   [N];
  logic          ok_r  [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [RW-1:0] r_in, trial, dv;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic          ok_s, take;

    if (j == 0) begin : g_first
      // Quotients of 4.0 and above can never win: drop them here
      assign r_in = RW'(num);
      assign d_in = den;
      assign q_in = '0;
      assign ok_s = ok_in && (RW'(num) < (RW'(den) << 2));
    end else begin : g_next
      assign r_in = rem_r[j-1];
      assign d_in = den_r[j-1];
      assign q_in = q_r[j-1];
      assign ok_s = ok_r[j-1];
    end

    // The two integer bits compare against 2D and D, then shift-and-subtract
    assign trial = (j >= 2) ? {r_in[RW-2:0], 1'b0} : r_in;
    assign dv    = (j == 0) ? (RW'(d_in) << 1) : RW'(d_in);
    assign take  = (trial >= dv);

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j]  <= {q_in[QW-2:0], take};
        ok_r[j] <= ok_s;
      end
    end

    if (j < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= take ? trial - dv : trial;
          den_r[j] <= d_in;
        end
      end
    end
  end

  assign quot   = q_r[N-1];
  assign ok_out = ok_r[N-1];

endmodule

@@ rtl/ssc_back.sv @@
// Back end: a divider for each edge, span test, edge selection and impact point
`timescale 1ns / 1ps

module ssc_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  ssc_pkg::item_t                      pop_item,
  input  ssc_pkg::edges_t                     edges,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_crossed,
  output logic [ssc_pkg::QuotW-1:0]           out_fraction,
  output logic signed [ssc_pkg::CoordW-1:0]   out_impact_x,
  output logic signed [ssc_pkg::CoordW-1:0]   out_impact_y,
  output logic signed [ssc_pkg::CoordW-1:0]   out_impact_z
);

  localparam int N  = ssc_pkg::DivStages;
  localparam int L  = ssc_pkg::Lanes;
  localparam int QW = ssc_pkg::QuotW;
  localparam int FB = ssc_pkg::FracBits;
  localparam int PW = ssc_pkg::ProdW;

  logic adv;

  // Divider stages
  logic [N-1:0]      vld_r;
  ssc_pkg::item_t    side_r [N];
  logic [QW-1:0]     dq  [L];
  logic              dok [L];

  // Product stage
  logic              m_vld_r;
  ssc_pkg::item_t    m_side_r;
  logic [QW-1:0]     m_q_r  [L];
  logic              m_ok_r [L];
  logic [PW-1:0]     m_p_r  [L];

  // Span stage
  logic                                  c_vld_r;
  ssc_pkg::item_t                        c_side_r;
  logic [QW-1:0]                         c_q_r    [L];
  logic signed [ssc_pkg::InterW-1:0]     c_c_r    [L];
  logic                                  c_cand_r [L];
  logic signed [ssc_pkg::InterW-1:0]     c_new    [L];
  logic signed [ssc_pkg::CoordW-1:0]     sb       [L];
  logic signed [ssc_pkg::DeltaW-1:0]     db       [L];
  logic signed [ssc_pkg::EdgeW-1:0]      lo       [L];
  logic signed [ssc_pkg::EdgeW-1:0]      hi       [L];

  // Selection stage
  logic                                  s_vld_r;
  logic [QW-1:0]                         s_best_r;
  logic [1:0]                            s_win_r;
  logic                                  s_cross_r;
  logic signed [ssc_pkg::InterW-1:0]     s_cwin_r;
  logic signed [ssc_pkg::CoordW-1:0]     s_sz_r;
  logic signed [ssc_pkg::DeltaW-1:0]     s_dz_r;
  logic [ssc_pkg::DeltaW-1:0]            s_dmz_r;
  logic [QW-1:0]                         best;
  logic [1:0]                            win;

  // Depth product stage
  logic                                  z_vld_r;
  logic [PW-1:0]                         z_p_r;
  logic [QW-1:0]                         z_best_r;
  logic [1:0]                            z_win_r;
  logic                                  z_cross_r;
  logic signed [ssc_pkg::InterW-1:0]     z_cwin_r;
  logic signed [ssc_pkg::CoordW-1:0]     z_sz_r;
  logic signed [ssc_pkg::DeltaW-1:0]     z_dz_r;

  // Output register
  logic                                  o_vld_r;
  logic                                  o_cross_r;
  logic [QW-1:0]                         o_frac_r;
  logic signed [ssc_pkg::CoordW-1:0]     o_ix_r, o_iy_r, o_iz_r;
  logic signed [ssc_pkg::EdgeW-1:0]      edge_win;
  logic signed [ssc_pkg::InterW-1:0]     iz;

  // Whole pipeline moves unless a finished result is held
  assign adv       = !o_vld_r || out_ready;
  assign pop_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      m_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
      z_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r   <= {vld_r[N-2:0], pop_valid};
      m_vld_r <= vld_r[N-1];
      c_vld_r <= m_vld_r;
      s_vld_r <= c_vld_r;
      z_vld_r <= s_vld_r;
      o_vld_r <= z_vld_r;
    end
  end

  // Segment data alongside the dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= pop_item;
      for (int k = 1; k < N; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  for (genvar i = 0; i < L; i++) begin : g_lane
    ssc_div u_div (
      .clk    (clk),
      .en     (adv),
      .num    (pop_item.num_mag[i]),
      .den    ((i < 2) ? pop_item.dmx : pop_item.dmy),
      .ok_in  (pop_item.ok[i]),
      .quot   (dq[i]),
      .ok_out (dok[i])
    );
  end

  // Scale the crossing extent by each fraction
  always_ff @(posedge clk) begin
    if (adv) begin
      m_side_r <= side_r[N-1];
      for (int i = 0; i < L; i++) begin
        m_q_r[i]  <= dq[i];
        m_ok_r[i] <= dok[i] && (dq[i] <= ssc_pkg::FracNone);
        m_p_r[i]  <= PW'((i < 2) ? side_r[N-1].dmy : side_r[N-1].dmx) * PW'(dq[i]);
      end
    end
  end

  // Crossing point on the other axis and span test
  always_comb begin
    for (int i = 0; i < L; i++) begin
      sb[i] = (i < 2) ? m_side_r.sy : m_side_r.sx;
      db[i] = (i < 2) ? m_side_r.dy : m_side_r.dx;
      lo[i] = (i < 2) ? edges.top : edges.left;
      hi[i] = (i < 2) ? edges.bottom : edges.right;
      c_new[i] = ssc_pkg::interp(sb[i], db[i], m_p_r[i][PW-1:FB]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_side_r <= m_side_r;
      for (int i = 0; i < L; i++) begin
        c_q_r[i]    <= m_q_r[i];
        c_c_r[i]    <= c_new[i];
        c_cand_r[i] <= m_ok_r[i] && (c_new[i] >= ssc_pkg::InterW'(lo[i])) &&
                       (c_new[i] <= ssc_pkg::InterW'(hi[i]));
      end
    end
  end

  // Edge selection in test order; later edges win ties
  always_comb begin
    best = ssc_pkg::FracNone;
    win  = ssc_pkg::LaneLeft;
    for (int i = 0; i < L; i++) begin
      if (c_cand_r[i] && (c_q_r[i] <= best)) begin
        best = c_q_r[i];
        win  = 2'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_best_r  <= best;
      s_win_r   <= win;
      s_cross_r <= (best <= ssc_pkg::FracOne);
      s_cwin_r  <= c_c_r[win];
      s_sz_r    <= c_side_r.sz;
      s_dz_r    <= c_side_r.dz;
      s_dmz_r   <= c_side_r.dmz;
    end
  end

  // Depth interpolation product
  always_ff @(posedge clk) begin
    if (adv) begin
      z_p_r     <= PW'(s_dmz_r) * PW'(s_best_r);
      z_best_r  <= s_best_r;
      z_win_r   <= s_win_r;
      z_cross_r <= s_cross_r;
      z_cwin_r  <= s_cwin_r;
      z_sz_r    <= s_sz_r;
      z_dz_r    <= s_dz_r;
    end
  end

  // Impact point assembly
  always_comb begin
    case (z_win_r)
      ssc_pkg::LaneLeft:   edge_win = edges.left;
      ssc_pkg::LaneRight:  edge_win = edges.right;
      ssc_pkg::LaneTop:    edge_win = edges.top;
      ssc_pkg::LaneBottom: edge_win = edges.bottom;
      default:             edge_win = edges.left;
    endcase
    iz = ssc_pkg::interp(z_sz_r, z_dz_r, z_p_r[PW-1:FB]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_cross_r <= z_cross_r;
      o_frac_r  <= z_best_r;
      if (!z_cross_r) begin
        o_ix_r <= '0;
        o_iy_r <= '0;
        o_iz_r <= '0;
      end else if (z_win_r == ssc_pkg::LaneLeft || z_win_r == ssc_pkg::LaneRight) begin
        o_ix_r <= edge_win[ssc_pkg::CoordW-1:0];
        o_iy_r <= z_cwin_r[ssc_pkg::CoordW-1:0];
        o_iz_r <= iz[ssc_pkg::CoordW-1:0];
      end else begin
        o_ix_r <= z_cwin_r[ssc_pkg::CoordW-1:0];
        o_iy_r <= edge_win[ssc_pkg::CoordW-1:0];
        o_iz_r <= iz[ssc_pkg::CoordW-1:0];
      end
    end
  end

  assign out_valid    = o_vld_r;
  assign out_crossed  = o_cross_r;
  assign out_fraction = o_frac_r;
  assign out_impact_x = o_ix_r;
  assign out_impact_y = o_iy_r;
  assign out_impact_z = o_iz_r;

endmodule
